// File: hw/rtl/lcd_sess_pkg.sv
// Shared types, codes and the CRC-8 helper of the panel link session handler.
`default_nettype none

package lcd_sess_pkg;

    // Item opcodes
    localparam logic [1:0] OP_ISSUE    = 2'd0;
    localparam logic [1:0] OP_RESPONSE = 2'd1;
    localparam logic [1:0] OP_SET_BL   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_CRC_SEED = 1'b0;
    localparam logic CFG_GRACE    = 1'b1;

    // Request codes
    localparam logic [7:0] CODE_TOUCH   = 8'h40;
    localparam logic [7:0] CODE_INFO    = 8'h60;
    localparam logic [7:0] CODE_BL_INIT = 8'h7F;
    localparam logic       BL_FLAG      = 1'b1;
    localparam logic [6:0] LEVEL_MAX    = 7'd127;
    localparam logic [11:0] COORD_NONE  = 12'hFFF;
    localparam logic [7:0] TYPE_NONE    = 8'hFF;
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [6:0] FW_YEAR_MUL  = 7'd100;

    // Reset values of the configuration registers
    localparam logic [7:0]  SEED_RESET  = 8'hAC;
    localparam logic [15:0] GRACE_RESET = 16'd100;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] response_word;
        logic [7:0]  brightness_level;
    } item_t;

    typedef struct packed {
        logic        request_valid;
        logic [15:0] request_word;
        logic        crc_ok;
        logic [11:0] touch_x;
        logic [11:0] touch_y;
        logic        touch_down;
        logic        touch_new;
        logic [7:0]  panel_type;
        logic [14:0] firmware_version;
        logic        backlight_ready;
        logic [31:0] sessions_received;
        logic [31:0] crc_errors;
    } res_t;

    // CRC-8, MSB first, no reflection, no final xor
    function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] v);
        logic [7:0] c;
        c = acc ^ v;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lcd_sess_core.sv
// Session state registers and the single-pass update for one item.
`default_nettype none

module lcd_sess_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire lcd_sess_pkg::item_t item,
    input  wire logic [7:0]          crc_seed,
    input  wire logic [15:0]         grace,
    output lcd_sess_pkg::res_t       res
);
    import lcd_sess_pkg::*;

    logic        busy_reg, busy_next;
    logic [7:0]  outst_reg, outst_next;
    logic [7:0]  ptype_reg, ptype_next;
    logic [14:0] fw_reg, fw_next;
    logic        bl_conf_reg, bl_conf_next;
    logic        bl_ack_reg, bl_ack_next;
    logic [7:0]  pend_reg, pend_next;
    logic        tdown_reg, tdown_next;
    logic [11:0] tx_reg, tx_next;
    logic [11:0] ty_reg, ty_next;
    logic [31:0] rcv_reg, rcv_next;
    logic [31:0] err_reg, err_next;

    logic [7:0]  b3, b2, b1, b0;
    logic [7:0]  code;
    logic [7:0]  resp_crc;
    logic [11:0] new_x, new_y;
    logic        new_down;
    logic [6:0]  lvl;
    logic [14:0] fw_calc;

    assign b3 = item.response_word[31:24];
    assign b2 = item.response_word[23:16];
    assign b1 = item.response_word[15:8];
    assign b0 = item.response_word[7:0];

    assign resp_crc = crc_byte(crc_byte(crc_byte(crc_seed, b3), b2), b1);
    assign new_x    = {b3[7:4], b2};
    assign new_y    = {b3[3:0], b1};
    assign new_down = (new_x != COORD_NONE) && (new_y != COORD_NONE);
    assign lvl      = item.brightness_level[7] ? LEVEL_MAX : item.brightness_level[6:0];
    assign fw_calc  = 15'(b2) * 15'(FW_YEAR_MUL) + 15'(b1);

    always_comb
    begin
        busy_next    = busy_reg;
        outst_next   = outst_reg;
        ptype_next   = ptype_reg;
        fw_next      = fw_reg;
        bl_conf_next = bl_conf_reg;
        bl_ack_next  = bl_ack_reg;
        pend_next    = pend_reg;
        tdown_next   = tdown_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        rcv_next     = rcv_reg;
        err_next     = err_reg;
        code         = CODE_TOUCH;
        res          = '0;

        case (item.opcode)
            OP_ISSUE:
            begin
                if (ptype_reg == 8'd0) begin
                    code = CODE_INFO;
                end else if (!bl_conf_reg) begin
                    code = CODE_BL_INIT;
                end else if (pend_reg != 8'd0) begin
                    code      = pend_reg;
                    pend_next = 8'd0;
                end
                if (!busy_reg) begin
                    busy_next         = 1'b1;
                    outst_next        = code;
                    res.request_valid = 1'b1;
                    res.request_word  = {code, crc_byte(crc_seed, code)};
                end
            end
            OP_RESPONSE:
            begin
                if (busy_reg) begin
                    busy_next = 1'b0;
                    rcv_next  = rcv_reg + 32'd1;
                    if (resp_crc != b0) begin
                        if (rcv_next > {16'd0, grace}) begin
                            err_next = err_reg + 32'd1;
                        end
                    end else begin
                        res.crc_ok = 1'b1;
                        if (outst_reg == CODE_TOUCH) begin
                            // a release after a release is dropped
                            if (new_down || tdown_reg) begin
                                tdown_next    = new_down;
                                tx_next       = new_x;
                                ty_next       = new_y;
                                res.touch_new = 1'b1;
                            end
                        end else if (outst_reg == CODE_INFO) begin
                            if (b3 != TYPE_NONE) begin
                                ptype_next = b3;
                                fw_next    = fw_calc;
                            end
                        end else begin
                            bl_ack_next  = 1'b1;
                            bl_conf_next = 1'b1;
                        end
                    end
                end
            end
            OP_SET_BL:
            begin
                bl_ack_next = 1'b0;
                pend_next   = {BL_FLAG, lvl};
            end
            default:
            begin
            end
        endcase

        res.touch_x           = tx_next;
        res.touch_y           = ty_next;
        res.touch_down        = tdown_next;
        res.panel_type        = ptype_next;
        res.firmware_version  = fw_next;
        res.backlight_ready   = bl_ack_next;
        res.sessions_received = rcv_next;
        res.crc_errors        = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg    <= 1'b0;
            outst_reg   <= 8'd0;
            ptype_reg   <= 8'd0;
            fw_reg      <= 15'd0;
            bl_conf_reg <= 1'b0;
            bl_ack_reg  <= 1'b0;
            pend_reg    <= 8'd0;
            tdown_reg   <= 1'b0;
            tx_reg      <= 12'd0;
            ty_reg      <= 12'd0;
            rcv_reg     <= 32'd0;
            err_reg     <= 32'd0;
        end else if (step_en) begin
            busy_reg    <= busy_next;
            outst_reg   <= outst_next;
            ptype_reg   <= ptype_next;
            fw_reg      <= fw_next;
            bl_conf_reg <= bl_conf_next;
            bl_ack_reg  <= bl_ack_next;
            pend_reg    <= pend_next;
            tdown_reg   <= tdown_next;
            tx_reg      <= tx_next;
            ty_reg      <= ty_next;
            rcv_reg     <= rcv_next;
            err_reg     <= err_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd_link_session_handler_unit.sv
// Top level of the panel link session handler: input register, core, result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: opcode
//   (0 issue request, 1 response received, 2 set backlight level),
//   response_word and brightness_level. Output channel (out_valid/out_ready)
//   returns exactly one result beat per input beat, in order.
//   Config port: cfg_we with cfg_index (0 crc_seed, 1 error_grace_count)
//   and cfg_wdata, written on the clock edge; only while the block is idle, a rule
//   for the user that the block itself does not enforce.
// Pipeline: input register, then the single-pass update into the result register,
//   which drives out_valid.
// Throughput: one item per cycle unless stalled; the whole session update (three
//   chained CRC-8 bytes, decode, counters) sits between the input and result regs.
// Reset: all session state, the pipeline valids and the config registers
//   clear (crc_seed 0xAC, error_grace_count 100).
// Stall: when out_ready is low with a result held, the pipeline holds; the input
//   register still takes one more beat if it is empty, then in_ready drops.
`default_nettype none

module lcd_link_session_handler_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] response_word,
    input  wire logic [7:0]  brightness_level,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             request_valid,
    output logic [15:0]      request_word,
    output logic             crc_ok,
    output logic [11:0]      touch_x,
    output logic [11:0]      touch_y,
    output logic             touch_down,
    output logic             touch_new,
    output logic [7:0]       panel_type,
    output logic [14:0]      firmware_version,
    output logic             backlight_ready,
    output logic [31:0]      sessions_received,
    output logic [31:0]      crc_errors,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import lcd_sess_pkg::*;

    logic        in_valid_reg;
    item_t       item_reg;
    logic        out_valid_reg;
    res_t        res_reg;
    res_t        res_comb;
    logic [7:0]  seed_reg;
    logic [15:0] grace_reg;
    logic        advance;

    // Pipeline moves when the result register is free or being drained.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance || !in_valid_reg;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seed_reg  <= SEED_RESET;
            grace_reg <= GRACE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CRC_SEED: seed_reg  <= cfg_wdata[7:0];
                CFG_GRACE:    grace_reg <= cfg_wdata;
                default:      seed_reg  <= seed_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_reg <= '{opcode: opcode, response_word: response_word,
                          brightness_level: brightness_level};
        end
    end

    // Session state and per-item update; state commits as the beat moves on
    lcd_sess_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (in_valid_reg && advance),
        .item     (item_reg),
        .crc_seed (seed_reg),
        .grace    (grace_reg),
        .res      (res_comb)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg) begin
            res_reg <= res_comb;
        end
    end

    assign out_valid         = out_valid_reg;
    assign request_valid     = res_reg.request_valid;
    assign request_word      = res_reg.request_word;
    assign crc_ok            = res_reg.crc_ok;
    assign touch_x           = res_reg.touch_x;
    assign touch_y           = res_reg.touch_y;
    assign touch_down        = res_reg.touch_down;
    assign touch_new         = res_reg.touch_new;
    assign panel_type        = res_reg.panel_type;
    assign firmware_version  = res_reg.firmware_version;
    assign backlight_ready   = res_reg.backlight_ready;
    assign sessions_received = res_reg.sessions_received;
    assign crc_errors        = res_reg.crc_errors;

    // Checks
    a_req_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && request_valid) |->
            (request_word[15:8] == CODE_INFO || request_word[15:8] == CODE_BL_INIT ||
             request_word[15:8] == CODE_TOUCH || request_word[15] == BL_FLAG))
        else $error("request code outside the known set");

    a_touch_needs_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && touch_new) |-> crc_ok)
        else $error("touch report without CRC match");

    a_panel_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && panel_type != 8'd0) |=>
            (!out_valid || panel_type != 8'd0))
        else $error("panel type returned to unknown");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the panel link session handler: predictor, scoreboard, stimulus.
import lcd_sess_pkg::*;

// Tracks the session state of the link, predicts one report per accepted beat and
// checks the reports that come back, in order.
class session_scoreboard;
    // configuration copy
    logic [7:0]  seed  = SEED_RESET;
    logic [15:0] grace = GRACE_RESET;

    // session state
    logic        busy          = 1'b0;
    logic [7:0]  in_flight     = 8'h00;
    logic [7:0]  panel         = 8'h00;
    logic [14:0] firmware      = '0;
    logic        bl_confirmed  = 1'b0;
    logic        bl_ack        = 1'b0;
    logic [7:0]  pending_level = 8'h00;   // 0 = nothing pending
    logic [24:0] touch         = '0;      // {down, x, y}
    logic [31:0] sessions_seen = '0;
    logic [31:0] crc_failures  = '0;

    res_t awaited_reports[$];

    int mismatches    = 0;
    int reports_seen  = 0;
    int words_sent    = 0;
    int crc_matches   = 0;
    int touch_reports = 0;

    // MSB-first CRC-8, one data bit per step
    function logic [7:0] crc_step(logic [7:0] acc, logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = r[7] ^ data[k];
            r  = {r[6:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    function logic [7:0] crc_of_payload(logic [23:0] data);
        return crc_step(crc_step(crc_step(seed, data[23:16]), data[15:8]), data[7:0]);
    endfunction

    function void note_item(logic [1:0] op, logic [31:0] word, logic [7:0] level);
        res_t        r;
        logic [7:0]  code;
        logic [11:0] x;
        logic [11:0] y;
        logic        down;
        logic [6:0]  lvl;
        r = '0;
        case (op)
            OP_ISSUE:
            begin
                if (panel == 8'h00)
                    code = CODE_INFO;
                else if (!bl_confirmed)
                    code = CODE_BL_INIT;
                else if (pending_level != 8'h00)
                begin
                    code = pending_level;
                    pending_level = 8'h00;
                end
                else
                    code = CODE_TOUCH;
                if (!busy)
                begin
                    busy = 1'b1;
                    in_flight = code;
                    r.request_valid = 1'b1;
                    r.request_word = {code, crc_step(seed, code)};
                    words_sent++;
                end
            end
            OP_RESPONSE:
            begin
                if (busy)
                begin
                    busy = 1'b0;
                    sessions_seen = sessions_seen + 32'd1;
                    if (crc_of_payload(word[31:8]) != word[7:0])
                    begin
                        if (sessions_seen > 32'(grace))
                            crc_failures = crc_failures + 32'd1;
                    end
                    else
                    begin
                        r.crc_ok = 1'b1;
                        crc_matches++;
                        if (in_flight == CODE_TOUCH)
                        begin
                            x = {word[31:28], word[23:16]};
                            y = {word[27:24], word[15:8]};
                            down = (x != COORD_NONE) && (y != COORD_NONE);
                            // a release on top of a release is dropped
                            if (down || touch[24])
                            begin
                                touch = {down, x, y};
                                r.touch_new = 1'b1;
                                touch_reports++;
                            end
                        end
                        else if (in_flight == CODE_INFO)
                        begin
                            if (word[31:24] != TYPE_NONE)
                            begin
                                panel = word[31:24];
                                firmware = 15'(int'(word[23:16]) * FW_YEAR_MUL
                                               + int'(word[15:8]));
                            end
                        end
                        else
                        begin
                            bl_ack = 1'b1;
                            bl_confirmed = 1'b1;
                        end
                    end
                end
            end
            OP_SET_BL:
            begin
                lvl = (level > LEVEL_MAX) ? LEVEL_MAX : level[6:0];
                bl_ack = 1'b0;
                pending_level = {BL_FLAG, lvl};
            end
            default: ;
        endcase
        r.touch_x           = touch[23:12];
        r.touch_y           = touch[11:0];
        r.touch_down        = touch[24];
        r.panel_type        = panel;
        r.firmware_version  = firmware;
        r.backlight_ready   = bl_ack;
        r.sessions_received = sessions_seen;
        r.crc_errors        = crc_failures;
        awaited_reports.push_back(r);
    endfunction

    function string describe(res_t r);
        return $sformatf({"req %0b/%h ok %0b xy %0d,%0d down %0b new %0b",
                          " type %h fw %0d bl %0b rx %0d err %0d"},
                         r.request_valid, r.request_word, r.crc_ok, r.touch_x, r.touch_y,
                         r.touch_down, r.touch_new, r.panel_type, r.firmware_version,
                         r.backlight_ready, r.sessions_received, r.crc_errors);
    endfunction

    function void check_report(res_t got);
        res_t want;
        reports_seen++;
        if (awaited_reports.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: report %0d with no beat waiting: %s",
                         reports_seen, describe(got));
            return;
        end
        want = awaited_reports.pop_front();
        if (got.request_valid !== want.request_valid
            || got.request_word !== want.request_word
            || got.crc_ok !== want.crc_ok
            || got.touch_x !== want.touch_x
            || got.touch_y !== want.touch_y
            || got.touch_down !== want.touch_down
            || got.touch_new !== want.touch_new
            || got.panel_type !== want.panel_type
            || got.firmware_version !== want.firmware_version
            || got.backlight_ready !== want.backlight_ready
            || got.sessions_received !== want.sessions_received
            || got.crc_errors !== want.crc_errors)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: report %0d\n  expected %s\n  actual   %s",
                         reports_seen, describe(want), describe(got));
        end
    endfunction

    function int failures();
        return mismatches + awaited_reports.size();
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcd_sess_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;   // decodes to nothing
    localparam int         PIPE_LATENCY   = 2;      // input reg + result reg
    localparam int         SETTLE_CYCLES  = PIPE_LATENCY + 3;
    localparam int         HOLD_CYCLES    = 64;     // long receiver hold-off
    localparam int         WATCHDOG_LIMIT = 2000;   // cycles without any beat

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic        in_valid         = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode           = '0;
    logic [31:0] response_word    = '0;
    logic [7:0]  brightness_level = '0;

    // output channel
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        request_valid;
    logic [15:0] request_word;
    logic        crc_ok;
    logic [11:0] touch_x;
    logic [11:0] touch_y;
    logic        touch_down;
    logic        touch_new;
    logic [7:0]  panel_type;
    logic [14:0] firmware_version;
    logic        backlight_ready;
    logic [31:0] sessions_received;
    logic [31:0] crc_errors;

    // configuration port
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = '0;

    session_scoreboard sessions = new;

    int items_sent    = 0;
    int config_writes = 0;
    int quiet_cycles  = 0;
    bit no_gaps       = 1'b0;   // both sides run back to back while set
    bit hold_request  = 1'b0;   // receiver drops ready for HOLD_CYCLES when set
    int holds_done    = 0;

    lcd_link_session_handler_unit DUT (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d reports outstanding",
                     quiet_cycles, sessions.awaited_reports.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drives one input beat. Valid goes up after a random gap and then stays up,
    // payload frozen, until the beat is taken. Signals are sampled right after
    // the edge, so they show their pre-edge values.
    task automatic send_item(input logic [1:0] op, input logic [31:0] word,
                             input logic [7:0] level);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        opcode           <= op;
        response_word    <= word;
        brightness_level <= level;
        do
            @(posedge clk);
        while (!in_ready);
        sessions.note_item(op, word, level);
        items_sent++;
    endtask

    task automatic issue_request();
        send_item(OP_ISSUE, $urandom, 8'($urandom));
    endtask

    // Response beat over three data bytes; a bad one has a wrong CRC byte.
    task automatic deliver_response(input logic [23:0] data, input bit good);
        logic [7:0] crc;
        crc = sessions.crc_of_payload(data);
        if (!good)
            crc = crc ^ 8'($urandom_range(1, 255));
        send_item(OP_RESPONSE, {data, crc}, 8'($urandom));
    endtask

    task automatic set_level(input logic [7:0] level);
        send_item(OP_SET_BL, $urandom, level);
    endtask

    // One complete session: request, then its response.
    task automatic exchange(input logic [23:0] data, input bit good);
        issue_request();
        deliver_response(data, good);
    endtask

    // Response content: plenty of releases and the "no panel" type byte.
    function automatic logic [23:0] random_payload();
        logic [11:0] x;
        logic [11:0] y;
        int          pick;
        pick = $urandom_range(0, 9);
        x = 12'($urandom);
        y = 12'($urandom);
        if (pick < 2)
            x = COORD_NONE;
        else if (pick == 2)
            y = COORD_NONE;
        else if (pick == 3)
            return {TYPE_NONE, 16'($urandom)};
        return {x[11:8], y[11:8], x[7:0], y[7:0]};
    endfunction

    function automatic logic [7:0] random_level();
        if ($urandom_range(0, 1) == 1)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    // Stops offering beats and waits until every report is back, then lets the
    // pipeline settle so config writes land on an idle block.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (sessions.awaited_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers on consecutive edges; cfg_we stays up across them.
    task automatic write_config(input logic [7:0] seed_value, input logic [15:0] grace_value);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CRC_SEED;
        cfg_wdata <= {8'($urandom), seed_value};   // upper bits must be ignored
        @(posedge clk);
        cfg_index <= CFG_GRACE;
        cfg_wdata <= grace_value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sessions.seed  = seed_value;
        sessions.grace = grace_value;
        config_writes += 2;
    endtask

    // Walks the request-code ladder from reset: info, backlight init, pending
    // level, touch, with the corner cases along the way.
    task automatic run_directed();
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);   // unused opcode: state only
        deliver_response(24'h123456, 1'b1);          // stray, nothing outstanding
        set_level(8'hFF);                            // saturates to 127
        issue_request();                             // info request goes out
        issue_request();                             // still busy: no word
        deliver_response(24'h5A5A5A, 1'b0);          // bad CRC, zero grace counts it
        exchange({TYPE_NONE, 16'h0102}, 1'b1);       // "no panel" type ignored
        exchange(24'h00FFFF, 1'b1);                  // type 0, largest firmware
        exchange(24'hA5172D, 1'b1);                  // panel identified
        exchange(24'h000000, 1'b1);                  // backlight init acknowledged
        exchange(24'hFFFFFF, 1'b1);                  // pending level 127 sent
        set_level(8'h00);
        exchange(24'h000000, 1'b0);                  // level 0 sent, CRC fails
        exchange(24'h000000, 1'b1);                  // touch press at origin
        exchange({4'hF, 4'h3, 8'hFF, 8'h21}, 1'b1);  // release through x
        exchange({4'h2, 4'hF, 8'h10, 8'hFF}, 1'b1);  // second release, dropped
    endtask

    // Mostly complete sessions with random content, mixed with level writes,
    // double issues, stray responses and plain noise.
    task automatic run_traffic(input int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                exchange(random_payload(), $urandom_range(0, 6) != 0);
            else if (pick < 70)
                set_level(random_level());
            else if (pick < 78)
            begin
                issue_request();
                issue_request();
                deliver_response(random_payload(), $urandom_range(0, 4) != 0);
            end
            else if (pick < 84)
                deliver_response(random_payload(), 1'b1);
            else if (pick < 88)
                send_item(OP_UNUSED, $urandom, 8'($urandom));
            else
                send_item(2'($urandom_range(0, 3)), $urandom, 8'($urandom));
        end
    endtask

    // Receiver: random stalls per beat, one long hold-off on request; every
    // accepted report goes to the scoreboard.
    initial
    begin
        res_t got;
        int   stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                holds_done++;
                stall = 0;   // the hold-off already served as this beat's stall
            end
            else
                stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got.request_valid     = request_valid;
            got.request_word      = request_word;
            got.crc_ok            = crc_ok;
            got.touch_x           = touch_x;
            got.touch_y           = touch_y;
            got.touch_down        = touch_down;
            got.touch_new         = touch_new;
            got.panel_type        = panel_type;
            got.firmware_version  = firmware_version;
            got.backlight_ready   = backlight_ready;
            got.sessions_received = sessions_received;
            got.crc_errors        = crc_errors;
            sessions.check_report(got);
        end
    end

    // Sender and run control.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero seed, zero grace: every bad CRC counts from the first session.
        write_config(8'h00, 16'h0000);
        run_directed();
        wait_for_idle();

        // Full seed, grace never runs out. Starts with a back-to-back burst.
        write_config(8'hFF, 16'hFFFF);
        no_gaps = 1'b1;
        run_traffic(80);
        no_gaps = 1'b0;
        run_traffic(250);
        wait_for_idle();

        // Random setting; halfway through, the receiver holds off for a long
        // stretch while beats keep coming, so the pipeline fills and stalls.
        write_config(8'($urandom), 16'($urandom_range(0, 400)));
        run_traffic(150);
        hold_request = 1'b1;
        run_traffic(40);
        run_traffic(130);
        wait_for_idle();

        // Back to the reset values.
        write_config(SEED_RESET, GRACE_RESET);
        run_traffic(320);
        wait_for_idle();

        $display("Run: %0d beats in, %0d reports checked, %0d config writes, %0d long hold-offs",
                 items_sent, sessions.reports_seen, config_writes, holds_done);
        $display("Link: %0d request words, %0d CRC matches, %0d touch reports, %0d CRC errors",
                 sessions.words_sent, sessions.crc_matches, sessions.touch_reports,
                 sessions.crc_failures);
        if (sessions.failures() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
